@@ design/rrts_pkg.sv @@
// shared types, sizes and codes of the round-robin tick scheduler
package rrts_pkg;

	localparam int MAX_JOBS = 16;
	localparam int IDX_W    = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
	localparam int CNT_W    = $clog2(MAX_JOBS + 1);
	localparam int SUM_W    = IDX_W + 1;

	localparam logic OP_ADD  = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [15:0] SLOT_MAX = 16'hFFFF;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] arrival;
		logic [15:0] required;
	} arr_entry_t;

	typedef struct packed {
		logic [7:0]  id;
		logic [15:0] remaining;
	} rdy_entry_t;

	localparam int ARR_W = $bits(arr_entry_t);
	localparam int RDY_W = $bits(rdy_entry_t);

	typedef struct packed {
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic [IDX_W-1:0] head;
		logic [IDX_W-1:0] tail;
		logic             empty;
		logic             full;
	} fifo_sts_t;

endpackage

@@ design/rrts_ram.sv @@
// generic single-write, single-read ram with registered read data
module rrts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/rrts_fifo_ptr.sv @@
// head pointer and fill count of one circular job queue
module rrts_fifo_ptr (
	input  logic                clk,
	input  logic                arst_n,
	input  rrts_pkg::fifo_ctl_t ctl,
	output rrts_pkg::fifo_sts_t sts
);

	logic [rrts_pkg::IDX_W-1:0] head_q;
	logic [rrts_pkg::CNT_W-1:0] count_q;
	logic [rrts_pkg::SUM_W-1:0] sum;
	logic [rrts_pkg::SUM_W-1:0] sum_wrap;

	// head plus count stays below twice the depth, so one subtract wraps it
	always_comb begin
		sum = rrts_pkg::SUM_W'(head_q) + rrts_pkg::SUM_W'(count_q);
		if (sum >= rrts_pkg::SUM_W'(rrts_pkg::MAX_JOBS)) begin
			sum_wrap = sum - rrts_pkg::SUM_W'(rrts_pkg::MAX_JOBS);
		end else begin
			sum_wrap = sum;
		end
		sts.head  = head_q;
		sts.tail  = sum_wrap[rrts_pkg::IDX_W-1:0];
		sts.empty = (count_q == '0);
		sts.full  = (count_q == rrts_pkg::CNT_W'(rrts_pkg::MAX_JOBS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.pop) begin
				if (head_q == rrts_pkg::IDX_W'(rrts_pkg::MAX_JOBS - 1)) begin
					head_q <= '0;
				end else begin
					head_q <= head_q + 1'b1;
				end
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

@@ design/round_robin_tick_scheduler.sv @@
// round-robin scheduler top: request decode, queue memories and result register
//
// channel   signals                                         direction
// request   in_valid in_ready opcode job_id arrival_slot      in
//           required_slots
// result    out_valid out_ready slot_start run_id ran         out
//           entered halted idle done_res rejected
//
// each request is accepted in idle and then executed: the accept edge launches the head reads of
// both queue memories, and the execute edge uses the registered read data, writes
// back at most one entry per memory and loads the result register.
// a waiting result stalls only the execute step; while idle, a request can still be taken.
// reset clears the pointers, counts and time; the memories need no clearing.
module round_robin_tick_scheduler (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        opcode,
	input  logic [7:0]  job_id,
	input  logic [15:0] arrival_slot,
	input  logic [15:0] required_slots,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] slot_start,
	output logic [7:0]  run_id,
	output logic        ran,
	output logic        entered,
	output logic        halted,
	output logic        idle,
	output logic        done_res,
	output logic        rejected
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic st_q;

	logic        op_q;
	logic [7:0]  id_q;
	logic [15:0] arr_q;
	logic [15:0] req_q;
	logic [15:0] slot_q;

	rrts_pkg::fifo_ctl_t a_ctl, r_ctl;
	rrts_pkg::fifo_sts_t a_sts, r_sts;

	rrts_pkg::arr_entry_t a_rd, a_wr;
	rrts_pkg::rdy_entry_t r_rd, r_wr;
	logic a_we, r_we;

	logic go;
	logic due;
	logic [15:0] need;
	logic [15:0] slot_nxt;
	logic        res_ran, res_entered, res_halted, res_idle, res_done, res_rej;
	logic [7:0]  res_id;

	logic        out_valid_q;
	logic [15:0] slot_start_q;
	logic [7:0]  run_id_q;
	logic        ran_q, entered_q, halted_q, idle_q, done_q, rejected_q;

	rrts_fifo_ptr u_arr_ptr (.clk(clk), .arst_n(arst_n), .ctl(a_ctl), .sts(a_sts));
	rrts_fifo_ptr u_rdy_ptr (.clk(clk), .arst_n(arst_n), .ctl(r_ctl), .sts(r_sts));

	rrts_ram #(.WIDTH(rrts_pkg::ARR_W), .DEPTH(rrts_pkg::MAX_JOBS)) u_arr_ram (
		.clk(clk), .we(a_we), .waddr(a_sts.tail), .wdata(a_wr),
		.raddr(a_sts.head), .rdata(a_rd)
	);

	rrts_ram #(.WIDTH(rrts_pkg::RDY_W), .DEPTH(rrts_pkg::MAX_JOBS)) u_rdy_ram (
		.clk(clk), .we(r_we), .waddr(r_sts.tail), .wdata(r_wr),
		.raddr(r_sts.head), .rdata(r_rd)
	);

	assign in_ready = (st_q == S_IDLE);
	assign go       = (st_q == S_EXEC) && (!out_valid_q || out_ready);

	always_comb begin
		a_ctl       = '0;
		r_ctl       = '0;
		a_we        = 1'b0;
		r_we        = 1'b0;
		a_wr        = '{id: id_q, arrival: arr_q, required: req_q};
		r_wr        = '{id: r_rd.id, remaining: r_rd.remaining - 16'd1};
		res_ran     = 1'b0;
		res_entered = 1'b0;
		res_halted  = 1'b0;
		res_idle    = 1'b0;
		res_done    = 1'b0;
		res_rej     = 1'b0;
		res_id      = '0;
		slot_nxt    = (slot_q == rrts_pkg::SLOT_MAX) ? slot_q : slot_q + 16'd1;
		due         = !a_sts.empty && (a_rd.arrival <= slot_q);
		need        = (a_rd.required == '0) ? 16'd1 : a_rd.required;
		if (op_q == rrts_pkg::OP_ADD) begin
			slot_nxt = slot_q;
			if (a_sts.full) begin
				res_rej = 1'b1;
			end else begin
				a_we       = go;
				a_ctl.push = go;
			end
		end else if (due && !r_sts.full) begin
			a_ctl.pop   = go;
			res_ran     = 1'b1;
			res_entered = 1'b1;
			res_id      = a_rd.id;
			if (need > 16'd1) begin
				r_wr       = '{id: a_rd.id, remaining: need - 16'd1};
				r_we       = go;
				r_ctl.push = go;
			end else begin
				res_halted = 1'b1;
			end
		end else if (!r_sts.empty) begin
			r_ctl.pop = go;
			res_ran   = 1'b1;
			res_id    = r_rd.id;
			// requeue goes to the old tail; on a full queue that is the head slot the pop frees up
			if (r_rd.remaining > 16'd1) begin
				r_we       = go;
				r_ctl.push = go;
			end else begin
				res_halted = 1'b1;
			end
		end else if (!a_sts.empty) begin
			res_idle = 1'b1;
		end else begin
			res_done = 1'b1;
			slot_nxt = slot_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (st_q)
				S_IDLE: begin
					if (in_valid) begin
						st_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (go) begin
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
			if (go) begin
				slot_q      <= slot_nxt;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q  <= opcode;
			id_q  <= job_id;
			arr_q <= arrival_slot;
			req_q <= required_slots;
		end
		if (go) begin
			slot_start_q <= slot_q;
			run_id_q     <= res_id;
			ran_q        <= res_ran;
			entered_q    <= res_entered;
			halted_q     <= res_halted;
			idle_q       <= res_idle;
			done_q       <= res_done;
			rejected_q   <= res_rej;
		end
	end

	assign out_valid  = out_valid_q;
	assign slot_start = slot_start_q;
	assign run_id     = run_id_q;
	assign ran        = ran_q;
	assign entered    = entered_q;
	assign halted     = halted_q;
	assign idle       = idle_q;
	assign done_res   = done_q;
	assign rejected   = rejected_q;

`ifndef ASSERT_OFF
	a_one_outcome: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> $onehot0({ran, idle, done_res, rejected}))
		else $error("more than one outcome flag in a result");

	a_flags_need_run: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (entered || halted) |-> ran)
		else $error("entered or halted without a running job");

	a_time_held: assert property (@(posedge clk) disable iff (!arst_n)
		!go |=> $stable(slot_q))
		else $error("time moved without a completed request");

	a_exec_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> st_q == S_EXEC && !in_ready)
		else $error("accepted request did not enter execution");
`endif

endmodule

@@ test/tb.sv @@
// testbench for the round-robin tick scheduler: random requests, built-in predictor, checks
`timescale 1ns / 100ps

module tb;

	typedef struct packed {
		logic        op;
		logic [7:0]  id;
		logic [15:0] arrival;
		logic [15:0] required;
	} sched_req_t;

	typedef struct packed {
		logic [15:0] slot_start;
		logic [7:0]  run_id;
		logic        ran;
		logic        entered;
		logic        halted;
		logic        idle;
		logic        done_res;
		logic        rejected;
	} slot_report_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        opcode = rrts_pkg::OP_ADD;
	logic [7:0]  job_id = '0;
	logic [15:0] arrival_slot = '0;
	logic [15:0] required_slots = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] slot_start;
	logic [7:0]  run_id;
	logic        ran;
	logic        entered;
	logic        halted;
	logic        idle;
	logic        done_res;
	logic        rejected;

	round_robin_tick_scheduler uut (
		.clk, .arst_n, .in_valid, .in_ready, .opcode, .job_id, .arrival_slot,
		.required_slots, .out_valid, .out_ready, .slot_start, .run_id, .ran,
		.entered, .halted, .idle, .done_res, .rejected
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// stimulus and predicted reports
	sched_req_t   request_queue[$];
	slot_report_t due_reports[$];
	sched_req_t   next_req;
	int           est_ticks = 0;
	int           sent_cnt = 0;
	int           half_mark = 1000000;
	int           main_total = 1000000;
	int           total_reqs = 1000000;
	int           n_errors = 0;
	logic         hold_off = 1'b0;

	// predictor state
	rrts_pkg::arr_entry_t arr_q[rrts_pkg::MAX_JOBS];
	rrts_pkg::rdy_entry_t rdy_q[rrts_pkg::MAX_JOBS];
	int           arr_head = 0;
	int           arr_cnt = 0;
	int           rdy_head = 0;
	int           rdy_cnt = 0;
	logic [15:0]  now_slot = '0;

	task automatic push_ready(input logic [7:0] id, input logic [15:0] remaining);
		rdy_q[(rdy_head + rdy_cnt) % rrts_pkg::MAX_JOBS] = '{id: id, remaining: remaining};
		rdy_cnt++;
	endtask

	task automatic schedule_one(input sched_req_t r);
		slot_report_t rep;
		rrts_pkg::arr_entry_t a;
		rrts_pkg::rdy_entry_t y;
		logic [15:0]  need;
		logic         busy;
		rep = '0;
		rep.slot_start = now_slot;
		busy = 1'b0;
		if (r.op == rrts_pkg::OP_ADD) begin
			if (arr_cnt >= rrts_pkg::MAX_JOBS)
				rep.rejected = 1'b1;
			else begin
				arr_q[(arr_head + arr_cnt) % rrts_pkg::MAX_JOBS] =
					'{id: r.id, arrival: r.arrival, required: r.required};
				arr_cnt++;
			end
		end else if (arr_cnt > 0 && arr_q[arr_head].arrival <= now_slot &&
				rdy_cnt < rrts_pkg::MAX_JOBS) begin
			a = arr_q[arr_head];
			need = (a.required == 16'd0) ? 16'd1 : a.required;
			arr_head = (arr_head + 1) % rrts_pkg::MAX_JOBS;
			arr_cnt--;
			rep.ran = 1'b1;
			rep.entered = 1'b1;
			rep.run_id = a.id;
			if (need > 16'd1)
				push_ready(a.id, need - 16'd1);
			else
				rep.halted = 1'b1;
			busy = 1'b1;
		end else if (rdy_cnt > 0) begin
			// also taken when the arrival head is due but the ready queue is full
			y = rdy_q[rdy_head];
			rdy_head = (rdy_head + 1) % rrts_pkg::MAX_JOBS;
			rdy_cnt--;
			rep.ran = 1'b1;
			rep.run_id = y.id;
			if (y.remaining > 16'd1)
				push_ready(y.id, y.remaining - 16'd1);
			else
				rep.halted = 1'b1;
			busy = 1'b1;
		end else if (arr_cnt > 0) begin
			rep.idle = 1'b1;
			busy = 1'b1;
		end else begin
			rep.done_res = 1'b1;
		end
		if (busy && now_slot != rrts_pkg::SLOT_MAX)
			now_slot = now_slot + 16'd1;
		due_reports.push_back(rep);
	endtask

	// stimulus builders
	task automatic queue_add(input logic [7:0] id, input logic [15:0] arrival,
			input logic [15:0] required);
		sched_req_t r;
		r.op = rrts_pkg::OP_ADD;
		r.id = id;
		r.arrival = arrival;
		r.required = required;
		request_queue.push_back(r);
	endtask

	task automatic queue_ticks(input int n);
		sched_req_t r;
		for (int i = 0; i < n; i++) begin
			r.op = rrts_pkg::OP_TICK;
			r.id = 8'($urandom);
			r.arrival = 16'($urandom);
			r.required = 16'($urandom);
			request_queue.push_back(r);
			est_ticks++;
		end
	endtask

	function automatic logic [15:0] near_arrival();
		return 16'($urandom_range(0, est_ticks + 4));
	endfunction

	function automatic logic [15:0] short_need();
		if ($urandom_range(0, 9) == 0)
			return 16'($urandom_range(1, 30));
		return 16'($urandom_range(1, 4));
	endfunction

	// overfill the arrival queue with due multi-slot jobs that back up the ready queue, then add more jobs
	task automatic queue_fill_burst();
		int n;
		n = $urandom_range(16, 20);
		for (int i = 0; i < n; i++)
			queue_add(8'($urandom), 16'($urandom_range(0, est_ticks)),
				16'($urandom_range(2, 4)));
		queue_ticks($urandom_range(16, 24));
		n = $urandom_range(2, 6);
		for (int i = 0; i < n; i++)
			queue_add(8'($urandom), 16'($urandom_range(0, est_ticks)), short_need());
		queue_ticks($urandom_range(4, 40));
	endtask

	function automatic bit roll_pause(input int pct);
		return $urandom_range(0, 99) < pct;
	endfunction

	function automatic int phase_now();
		if (sent_cnt < half_mark)
			return 0;
		if (sent_cnt < main_total)
			return 1;
		return 2;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				next_req.op = opcode;
				next_req.id = job_id;
				next_req.arrival = arrival_slot;
				next_req.required = required_slots;
				schedule_one(next_req);
				sent_cnt <= sent_cnt + 1;
			end
			if (!in_valid || in_ready) begin
				if (request_queue.size() > 0 &&
						!roll_pause(phase_now() == 0 ? 20 : phase_now() == 1 ? 77 : 0)) begin
					next_req = request_queue.pop_front();
					in_valid <= 1'b1;
					opcode <= next_req.op;
					job_id <= next_req.id;
					arrival_slot <= next_req.arrival;
					required_slots <= next_req.required;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	task automatic check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, act_v);
			n_errors++;
		end
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (due_reports.size() == 0) begin
					$display("%0t: result with no request outstanding, expected none, got slot_start %0d",
						$time, slot_start);
					n_errors++;
				end else begin
					check_field("slot_start", due_reports[0].slot_start, slot_start);
					check_field("run_id", due_reports[0].run_id, run_id);
					check_field("ran", due_reports[0].ran, ran);
					check_field("entered", due_reports[0].entered, entered);
					check_field("halted", due_reports[0].halted, halted);
					check_field("idle", due_reports[0].idle, idle);
					check_field("done_res", due_reports[0].done_res, done_res);
					check_field("rejected", due_reports[0].rejected, rejected);
					void'(due_reports.pop_front());
				end
			end
			out_ready <= !hold_off &&
				!roll_pause(phase_now() == 0 ? 77 : phase_now() == 1 ? 20 : 0);
		end
	end

	// long receiver stall so the block backs up into its input
	initial begin
		wait (sent_cnt >= 40);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		int n;
		// empty scheduler, zero-slot job, late arrival with idle slots, round robin
		queue_ticks(1);
		queue_add(8'h00, 16'd0, 16'd0);
		queue_ticks(1);
		queue_add(8'hFF, 16'd3, 16'd1);
		queue_ticks(3);
		queue_add(8'hAA, 16'd0, 16'd3);
		queue_add(8'h55, 16'd4, 16'd2);
		queue_ticks(6);
		queue_fill_burst();

		while (request_queue.size() < 380) begin
			case ($urandom_range(0, 9))
				0, 1, 2: queue_fill_burst();
				3, 4, 5, 6, 7: begin
					for (int i = 0; i < 12; i++) begin
						if ($urandom_range(0, 9) < 4)
							queue_add(8'($urandom), near_arrival(), short_need());
						else
							queue_ticks(1);
					end
				end
				8: queue_ticks($urandom_range(20, 60));
				default: begin
					// scattered short jobs and lone ticks
					n = $urandom_range(3, 8);
					for (int i = 0; i < n; i++) begin
						queue_add(8'($urandom), 16'($urandom_range(0, est_ticks)), 16'd1);
						queue_ticks($urandom_range(0, 3));
					end
				end
			endcase
		end
		main_total = request_queue.size();
		half_mark = main_total / 2;

		// short drain with a few late jobs and no idling
		queue_ticks(30);
		for (int i = 0; i < 6; i++)
			queue_add(8'($urandom), 16'($urandom), 16'($urandom_range(1, 3)));
		queue_ticks(10);
		total_reqs = request_queue.size();

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (sent_cnt == total_reqs);
		while (due_reports.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (n_errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

@@ files.f @@
design/rrts_pkg.sv
design/rrts_ram.sv
design/rrts_fifo_ptr.sv
design/round_robin_tick_scheduler.sv
test/tb.sv
